// ===== rtl/core/clt_pkg.sv =====
// shared types and constants for the command line tokenizer
package clt_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 4;
    localparam int INDEX_W = 2;

    // stream packing widths
    localparam int TDATA_W = 24;
    localparam int TUSER_W = 3;

    // parameter defaults
    localparam int MAX_ARGS_DEF   = 8;
    localparam int LINE_LIMIT_DEF = 255;

    // register reset values
    localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd36;
    localparam logic [BYTE_W-1:0] SEP_CHAR_RST   = 8'd32;
    localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'd10;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_START_CHAR = 2'd0;
    localparam logic [INDEX_W-1:0] REG_SEP_CHAR   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_END_CHAR   = 2'd2;

    // frame phase codes
    localparam logic [1:0] PH_IDLE    = 2'b00;
    localparam logic [1:0] PH_STARTED = 2'b01;
    localparam logic [1:0] PH_ARMED   = 2'b11;

    typedef struct packed {
        logic [BYTE_W-1:0] start_char;
        logic [BYTE_W-1:0] sep_char;
        logic [BYTE_W-1:0] end_char;
    } clt_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] field_number;
        logic               is_separator;
        logic               starts_field;
        logic               frame_done;
        logic [COUNT_W-1:0] arg_count;
        logic               forced_end;
    } clt_result_t;

endpackage

// ===== rtl/core/command_line_tokenizer_top.sv =====
// Command line tokenizer: splits framed command lines into stored bytes.
// Path: an accepted input beat goes to the input register; its result beat goes
// to the result register once that register has room.
// Throughput: one byte per cycle while the held byte retires; it retires when it
// makes no result or the result register is free or being emptied in the same cycle.
// Reset (aresetn low, synchronous): idle outside a frame, registers to defaults.
module command_line_tokenizer_top
    import clt_pkg::*;
#(
    parameter int MAX_ARGS   = MAX_ARGS_DEF,
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [TDATA_W-1:0]  m_axis_tdata,   // [7:0] out_byte, [15:8] position,
                                                // [19:16] field_number, [23:20] arg_count
    output logic [TUSER_W-1:0]  m_axis_tuser,   // [0] is_separator, [1] starts_field,
                                                // [2] forced_end
    output logic                m_axis_tlast,   // frame_done
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]   cfg_data
);

    clt_cfg_t    cfg;
    clt_result_t res;
    clt_result_t out_res;
    logic        res_valid;
    logic        out_free;
    logic        load;

    clt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clt_tokenizer #(
        .MAX_ARGS   (MAX_ARGS),
        .LINE_LIMIT (LINE_LIMIT)
    ) u_tok (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .cfg       (cfg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // a result loads only when it has room
    assign load = res_valid && out_free;

    clt_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // stream packing
    assign m_axis_tdata = {out_res.arg_count, out_res.field_number,
                           out_res.position, out_res.out_byte};
    assign m_axis_tuser = {out_res.forced_end, out_res.starts_field, out_res.is_separator};
    assign m_axis_tlast = out_res.frame_done;

endmodule

// ===== rtl/core/clt_cfg_regs.sv =====
// configuration registers for start, separator and end characters
module clt_cfg_regs
    import clt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]   cfg_data,
    output clt_cfg_t            cfg
);

    clt_cfg_t cfg_reg;
    clt_cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    // decode the register write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_CHAR: cfg_next.start_char = cfg_data;
                REG_SEP_CHAR:   cfg_next.sep_char   = cfg_data;
                REG_END_CHAR:   cfg_next.end_char   = cfg_data;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_char <= START_CHAR_RST;
            cfg_reg.sep_char   <= SEP_CHAR_RST;
            cfg_reg.end_char   <= END_CHAR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/clt_tokenizer.sv =====
// input register, frame state and per-byte tokenizing logic
module clt_tokenizer
    import clt_pkg::*;
#(
    parameter int MAX_ARGS   = MAX_ARGS_DEF,
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  in_byte,
    input  clt_cfg_t           cfg,
    input  logic               out_free,
    output logic               res_valid,
    output clt_result_t        res
);

    localparam logic [COUNT_W-1:0] MAX_ARGS_C   = COUNT_W'(MAX_ARGS);
    localparam logic [POS_W-1:0]   LINE_LIMIT_C = POS_W'(LINE_LIMIT);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [1:0]         phase_reg, phase_next;
    logic [POS_W-1:0]   wpos_reg, wpos_next;
    logic [COUNT_W-1:0] argc_reg, argc_next;
    logic               consume;
    logic               armed;
    logic [COUNT_W-1:0] argc_inc;

    assign armed    = (phase_reg == PH_ARMED);
    assign argc_inc = argc_reg + COUNT_W'(1);

    // classify the held byte and compute the result and next state
    always_comb begin
        res_valid  = 1'b0;
        res        = '0;
        phase_next = phase_reg;
        wpos_next  = wpos_reg;
        argc_next  = argc_reg;
        if (in_valid_reg && (in_byte_reg != '0)) begin
            priority if (phase_reg == PH_IDLE) begin
                if (in_byte_reg == cfg.start_char) begin
                    wpos_next  = '0;
                    argc_next  = '0;
                    phase_next = PH_STARTED;
                end
            end else if (wpos_reg >= LINE_LIMIT_C) begin
                // line full: drop the byte and close the frame
                res_valid        = 1'b1;
                res.position     = wpos_reg;
                res.field_number = argc_reg;
                res.arg_count    = argc_reg;
                res.frame_done   = 1'b1;
                res.forced_end   = 1'b1;
                phase_next       = PH_IDLE;
            end else if (in_byte_reg == cfg.sep_char) begin
                res_valid        = 1'b1;
                res.position     = wpos_reg;
                res.field_number = argc_reg;
                res.arg_count    = argc_reg;
                res.is_separator = 1'b1;
                wpos_next        = wpos_reg + POS_W'(1);
                phase_next       = PH_ARMED;
            end else if (in_byte_reg == cfg.end_char) begin
                res_valid        = 1'b1;
                res.position     = wpos_reg;
                res.field_number = argc_reg;
                res.arg_count    = argc_reg;
                res.frame_done   = 1'b1;
                phase_next       = PH_IDLE;
            end else if (armed && (argc_reg >= MAX_ARGS_C)) begin
                // argument limit reached: word bytes are dropped
                res_valid = 1'b0;
            end else begin
                res_valid        = 1'b1;
                res.out_byte     = in_byte_reg;
                res.position     = wpos_reg;
                res.starts_field = armed;
                res.field_number = armed ? argc_inc : argc_reg;
                res.arg_count    = armed ? argc_inc : argc_reg;
                argc_next        = armed ? argc_inc : argc_reg;
                wpos_next        = wpos_reg + POS_W'(1);
                phase_next       = PH_STARTED;
            end
        end
    end

    // the held byte retires when its result, if any, has room
    assign consume       = in_valid_reg && (!res_valid || out_free);
    assign in_ready      = !in_valid_reg || consume;
    assign in_valid_next = in_valid ? 1'b1 : (consume ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            wpos_reg     <= '0;
            argc_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (consume) begin
                phase_reg <= phase_next;
                wpos_reg  <= wpos_next;
                argc_reg  <= argc_next;
            end
        end
    end

    // input data register
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_byte_reg <= in_byte;
        end
    end

    a_argc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        argc_reg <= MAX_ARGS_C)
        else $error("argument count above limit");

    a_wpos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wpos_reg <= LINE_LIMIT_C)
        else $error("write position above line limit");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && res_valid && res.frame_done) |=> (phase_reg == PH_IDLE))
        else $error("frame end did not return to idle");

    a_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && (phase_reg == PH_IDLE) && (phase_next == PH_STARTED))
        |=> (wpos_reg == '0) && (argc_reg == '0))
        else $error("frame start did not clear position and count");

endmodule

// ===== rtl/core/clt_out_reg.sv =====
// result register feeding the output stream
module clt_out_reg
    import clt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  clt_result_t  res,
    output logic         out_free,
    output logic         out_valid,
    input  logic         out_ready,
    output clt_result_t  out_res
);

    logic        out_valid_reg, out_valid_next;
    clt_result_t out_res_reg;

    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (load) begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
